// ----- src/hgc_pkg.sv -----
// shared constants, the arc table function and register codes for the haversine geofence check
package hgc_pkg;

    localparam int CORDIC_STAGES_DEF = 24;
    localparam int SQRT_STEPS        = 32;
    localparam int XY_W              = 36;
    localparam int Z_W               = 36;
    localparam int LANES             = 4;

    localparam logic [29:0] RST_CENTER_LAT = 30'(-98777956);
    localparam logic [30:0] RST_CENTER_LON = 31'(-195594237);
    localparam logic [30:0] RST_RADIUS     = 31'd655360;

    localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
    localparam logic [32:0] TURN_RECIP      = 33'd6108397932;
    localparam logic [31:0] DIST_SCALE      = 32'd2623417457;
    localparam logic [30:0] DIST_MAX        = 31'd1311768576;

    typedef enum logic [1:0] {
        REG_CENTER_LAT = 2'd0,
        REG_CENTER_LON = 2'd1,
        REG_RADIUS     = 2'd2,
        REG_NONE       = 2'd3
    } t_reg_idx;

    function automatic logic [31:0] arc_of(input int idx);
        logic [31:0] v;
        unique case (idx)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            24: v = 32'h00000029;
            25: v = 32'h00000014;
            26: v = 32'h0000000A;
            27: v = 32'h00000005;
            28: v = 32'h00000003;
            29: v = 32'h00000001;
            30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

// ----- src/haversine_geofence_check.sv -----
// haversine geofence check: top level, angle conversion, products and result stage
// throughput one item per cycle while the pipe advances, set by the rows of
// cordic and square root cells
// the whole pipe advances unless a finished item waits behind a stalled output
// synchronous active-low reset clears valid bits and loads the default center and radius
module haversine_geofence_check
    import hgc_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [30:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [29:0] i_point_latitude,
    input  logic [30:0] i_point_longitude,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [30:0] o_distance,
    output logic        o_within_radius
);

    localparam int N     = CORDIC_STAGES;
    localparam int DEPTH = 40 + 2 * N;
    localparam int ROT0  = 3;
    localparam int P1    = ROT0 + N;
    localparam int SQ0   = P1 + 4;
    localparam int VEC0  = SQ0 + SQRT_STEPS;

    logic en;
    logic [DEPTH-1:0] r_vld;

    logic [29:0] r_center_latitude;
    logic [30:0] r_center_longitude;
    logic [30:0] r_radius_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_latitude  <= RST_CENTER_LAT;
            r_center_longitude <= RST_CENTER_LON;
            r_radius_limit     <= RST_RADIUS;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_CENTER_LAT: r_center_latitude  <= i_cfg_data[29:0];
                REG_CENTER_LON: r_center_longitude <= i_cfg_data;
                REG_RADIUS:     r_radius_limit     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic r_out_valid;
    assign en      = !(r_out_valid && i_stall && r_vld[DEPTH-1]);
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_valid};
        end
    end

    // angle to binary turns
    logic signed [32:0] w_v [LANES];
    always_comb begin
        w_v[0] = 33'(signed'(i_point_latitude)) - 33'(signed'(r_center_latitude));
        w_v[1] = 33'(signed'(i_point_longitude)) - 33'(signed'(r_center_longitude));
        w_v[2] = 33'(signed'(r_center_latitude)) <<< 1;
        w_v[3] = 33'(signed'(i_point_latitude)) <<< 1;
    end

    logic [31:0] r_mag  [LANES];
    logic        r_neg  [LANES];
    logic [31:0] r_mag2 [LANES];
    logic        r_neg2 [LANES];
    logic [33:0] r_q0   [LANES];
    logic [31:0] r_ang  [LANES];

    logic signed [XY_W-1:0] w_rx [LANES][N+1];
    logic signed [XY_W-1:0] w_ry [LANES][N+1];
    logic signed [Z_W-1:0]  w_rz [LANES][N+1];
    logic [N-1:0]           r_flip [LANES];

    genvar l, j;
    generate
        for (l = 0; l < LANES; l++) begin : g_lane
            logic [32:0] abs_v;
            logic [64:0] prod;
            logic [40:0] m_val;
            logic [40:0] p_val;
            logic [40:0] rem;
            logic [33:0] q;
            logic [31:0] a_add;
            logic        flip;
            logic [31:0] a_rot;

            always_comb begin
                abs_v = w_v[l][32] ? 33'(-w_v[l]) : 33'(w_v[l]);
                prod  = 65'(r_mag[l]) * 65'(TURN_RECIP);
                m_val = {2'b0, r_mag2[l], 7'b0} + 41'd45;
                p_val = 41'(r_q0[l]) * 41'd90;
                rem   = m_val - p_val;
                if (rem >= 41'd180) begin
                    q = r_q0[l] + 34'd2;
                end else if (rem >= 41'd90) begin
                    q = r_q0[l] + 34'd1;
                end else begin
                    q = r_q0[l];
                end
                a_add = r_ang[l] + 32'h40000000;
                flip  = a_add[31];
                a_rot = flip ? (r_ang[l] + 32'h80000000) : r_ang[l];
            end

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_mag[l]  <= abs_v[31:0];
                    r_neg[l]  <= w_v[l][32];
                    r_q0[l]   <= 34'(prod[64:32]);
                    r_mag2[l] <= r_mag[l];
                    r_neg2[l] <= r_neg[l];
                    r_ang[l]  <= r_neg2[l] ? (32'd0 - q[31:0]) : q[31:0];
                    r_flip[l] <= {r_flip[l][N-2:0], flip};
                end
            end

            assign w_rx[l][0] = XY_W'(signed'({1'b0, CORDIC_GAIN_Q30}));
            assign w_ry[l][0] = '0;
            assign w_rz[l][0] = Z_W'(signed'(a_rot));

            for (j = 0; j < N; j++) begin : g_rot
                hgc_cordic_cell #(.STAGE(j), .VECTORING(1'b0)) u_cell (
                    .i_clk (i_clk),
                    .i_en  (en),
                    .i_x   (w_rx[l][j]),
                    .i_y   (w_ry[l][j]),
                    .i_z   (w_rz[l][j]),
                    .o_x   (w_rx[l][j+1]),
                    .o_y   (w_ry[l][j+1]),
                    .o_z   (w_rz[l][j+1])
                );
            end
        end
    endgenerate

    // haversine term
    logic signed [XY_W-1:0] n_s1, n_s2, n_c1, n_c2;
    logic signed [31:0] s1, s2, c1, c2;
    always_comb begin
        n_s1 = r_flip[0][N-1] ? -w_ry[0][N] : w_ry[0][N];
        n_s2 = r_flip[1][N-1] ? -w_ry[1][N] : w_ry[1][N];
        n_c1 = r_flip[2][N-1] ? -w_rx[2][N] : w_rx[2][N];
        n_c2 = r_flip[3][N-1] ? -w_rx[3][N] : w_rx[3][N];
        s1 = n_s1[31:0];
        s2 = n_s2[31:0];
        c1 = n_c1[31:0];
        c2 = n_c2[31:0];
    end

    logic signed [63:0] r_p1_s1sq, r_p2_s1sq, r_p3_s1sq;
    logic signed [63:0] r_c1c2, r_ct, r_ts;
    logic signed [31:0] r_p1_s2, r_p2_s2;
    logic signed [31:0] cc, t_val;
    logic signed [65:0] a_sum;
    logic [60:0]        a_clamp;
    logic [63:0]        r_va, r_vb;

    always_comb begin
        cc    = r_c1c2[61:30];
        t_val = r_ct[61:30];
        a_sum = 66'(r_p3_s1sq) + 66'(r_ts);
        if (a_sum < 0) begin
            a_clamp = '0;
        end else if (a_sum > 66'sd1152921504606846976) begin
            a_clamp = 61'h1000000000000000;
        end else begin
            a_clamp = a_sum[60:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1_s1sq <= s1 * s1;
            r_c1c2    <= c1 * c2;
            r_p1_s2   <= s2;
            r_p2_s1sq <= r_p1_s1sq;
            r_p2_s2   <= r_p1_s2;
            r_ct      <= cc * r_p1_s2;
            r_p3_s1sq <= r_p2_s1sq;
            r_ts      <= t_val * r_p2_s2;
            r_va      <= {1'b0, a_clamp, 2'b00};
            r_vb      <= {1'b0, 61'h1000000000000000 - a_clamp, 2'b00};
        end
    end

    // square roots of a and 1 - a
    logic [63:0] w_sv [2][SQRT_STEPS+1];
    logic [63:0] w_sr [2][SQRT_STEPS+1];
    assign w_sv[0][0] = r_va;
    assign w_sv[1][0] = r_vb;
    assign w_sr[0][0] = '0;
    assign w_sr[1][0] = '0;

    generate
        for (l = 0; l < 2; l++) begin : g_sq
            for (j = 0; j < SQRT_STEPS; j++) begin : g_step
                hgc_sqrt_cell #(.SHIFT(62 - 2 * j)) u_cell (
                    .i_clk (i_clk),
                    .i_en  (en),
                    .i_v   (w_sv[l][j]),
                    .i_r   (w_sr[l][j]),
                    .o_v   (w_sv[l][j+1]),
                    .o_r   (w_sr[l][j+1])
                );
            end
        end
    endgenerate

    // central angle
    logic signed [XY_W-1:0] w_vx [N+1];
    logic signed [XY_W-1:0] w_vy [N+1];
    logic signed [Z_W-1:0]  w_vz [N+1];
    assign w_vx[0] = XY_W'({1'b0, w_sr[1][SQRT_STEPS][31:0]});
    assign w_vy[0] = XY_W'({1'b0, w_sr[0][SQRT_STEPS][31:0]});
    assign w_vz[0] = '0;

    generate
        for (j = 0; j < N; j++) begin : g_vec
            hgc_cordic_cell #(.STAGE(j), .VECTORING(1'b1)) u_cell (
                .i_clk (i_clk),
                .i_en  (en),
                .i_x   (w_vx[j]),
                .i_y   (w_vy[j]),
                .i_z   (w_vz[j]),
                .o_x   (w_vx[j+1]),
                .o_y   (w_vy[j+1]),
                .o_z   (w_vz[j+1])
            );
        end
    endgenerate

    logic [30:0] z_clamp;
    logic [62:0] r_prod;
    logic [63:0] rnd;
    logic [32:0] dist_full;
    logic [30:0] n_distance;
    logic [30:0] r_distance;
    logic        r_within;

    always_comb begin
        if (w_vz[N] < 0) begin
            z_clamp = '0;
        end else if (w_vz[N] > Z_W'(32'h40000000)) begin
            z_clamp = 31'h40000000;
        end else begin
            z_clamp = w_vz[N][30:0];
        end
        rnd        = 64'(r_prod) + 64'h40000000;
        dist_full  = rnd[63:31];
        n_distance = (dist_full > 33'(DIST_MAX)) ? DIST_MAX : dist_full[30:0];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod <= 63'(z_clamp) * 63'(DIST_SCALE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || !i_stall) begin
            r_out_valid <= r_vld[DEPTH-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_stall) begin
            r_distance <= n_distance;
            r_within   <= (n_distance <= r_radius_limit);
        end
    end

    assign o_valid         = r_out_valid;
    assign o_distance      = r_distance;
    assign o_within_radius = r_within;

    a_full_blocks_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall && r_vld[DEPTH-1]) |-> o_stall)
        else $error("finished item would be overwritten");

    a_dist_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_distance <= DIST_MAX))
        else $error("distance above saturation limit");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_vld[DEPTH-1]))
        else $error("result without item in last stage");

endmodule

// ----- src/hgc_cordic_cell.sv -----
// one cordic iteration cell, rotation or vectoring
module hgc_cordic_cell
    import hgc_pkg::*;
#(
    parameter int STAGE     = 0,
    parameter bit VECTORING = 1'b0
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic signed [XY_W-1:0] i_x,
    input  logic signed [XY_W-1:0] i_y,
    input  logic signed [Z_W-1:0]  i_z,
    output logic signed [XY_W-1:0] o_x,
    output logic signed [XY_W-1:0] o_y,
    output logic signed [Z_W-1:0]  o_z
);

    localparam logic signed [Z_W-1:0] ARC = Z_W'(arc_of(STAGE));

    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic                   pos;
    logic signed [XY_W-1:0] r_x, n_x;
    logic signed [XY_W-1:0] r_y, n_y;
    logic signed [Z_W-1:0]  r_z, n_z;

    always_comb begin
        dx  = i_x >>> STAGE;
        dy  = i_y >>> STAGE;
        pos = VECTORING ? !(i_y > 0) : (i_z >= 0);
        if (pos) begin
            n_x = i_x - dy;
            n_y = i_y + dx;
            n_z = i_z - ARC;
        end else begin
            n_x = i_x + dy;
            n_y = i_y - dx;
            n_z = i_z + ARC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

// ----- src/hgc_sqrt_cell.sv -----
// one digit step of the restoring integer square root
module hgc_sqrt_cell
    import hgc_pkg::*;
#(
    parameter int SHIFT = 62
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_v,
    input  logic [63:0] i_r,
    output logic [63:0] o_v,
    output logic [63:0] o_r
);

    localparam logic [63:0] BIT = 64'd1 << SHIFT;

    logic [63:0] rb;
    logic [63:0] r_v, n_v;
    logic [63:0] r_r, n_r;

    always_comb begin
        rb = i_r + BIT;
        if (i_v >= rb) begin
            n_v = i_v - rb;
            n_r = (i_r >> 1) + BIT;
        end else begin
            n_v = i_v;
            n_r = i_r >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v <= n_v;
            r_r <= n_r;
        end
    end

    assign o_v = r_v;
    assign o_r = r_r;

endmodule

// ----- tb/hgc_checker.sv -----
// checker for the haversine geofence check: predicts distance and flag per item and compares
module hgc_checker
    import hgc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [30:0] i_cfg_data,
    input  logic        i_valid,
    input  logic        i_stall_in,
    input  logic [29:0] i_point_latitude,
    input  logic [30:0] i_point_longitude,
    input  logic        i_valid_out,
    input  logic        i_stall,
    input  logic [30:0] i_distance,
    input  logic        i_within_radius,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [30:0] distance;
        logic        in_radius;
    } t_fix_result;

    t_fix_result expected_fixes[$];
    logic signed [63:0] ctr_lat;
    logic signed [63:0] ctr_lon;
    logic [63:0] radius;
    int fails;

    assign o_fail_count = fails;
    assign o_pending    = expected_fixes.size();

    function automatic logic signed [63:0] shr(input logic signed [63:0] v, input int s);
        return v >>> s;
    endfunction

    // degrees in 2^-22 units to binary angle, halves away from zero
    function automatic logic [31:0] bin_angle(input logic signed [63:0] v, input longint mul);
        longint n;
        longint q;
        n = v * mul;
        if (n >= 0) q = (2 * n + 45) / 90;
        else q = -((-2 * n + 45) / 90);
        return q[31:0];
    endfunction

    task automatic rotate(input logic [31:0] ang, output logic signed [63:0] s,
                          output logic signed [63:0] c);
        logic flip;
        logic signed [63:0] x, y, z, t, dx, dy;
        flip = 1'b0;
        x = 64'sd652032874;
        y = 0;
        if (((ang + 32'h40000000) & 32'h80000000) != 0) begin
            ang = ang + 32'h80000000;
            flip = 1'b1;
        end
        z = {{32{ang[31]}}, ang};
        for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
            dx = shr(x, i);
            dy = shr(y, i);
            if (z >= 0) begin
                t = x - dy; y = y + dx; x = t; z = z - $signed({32'd0, arc_of(i)});
            end else begin
                t = x + dy; y = y - dx; x = t; z = z + $signed({32'd0, arc_of(i)});
            end
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endtask

    function automatic logic [63:0] floor_root(input logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    task automatic predict_fix(input logic [29:0] plat, input logic [30:0] plon,
                               output t_fix_result res);
        logic signed [63:0] lat2, lon2, s1, s2, c1, c2, junk, cc, t, a, x, y, z, tt, dx, dy;
        logic [63:0] sy, sx, dist_q;
        lat2 = $signed(plat);
        lon2 = $signed(plon);
        rotate(bin_angle(lat2 - ctr_lat, 64), s1, junk);
        rotate(bin_angle(lon2 - ctr_lon, 64), s2, junk);
        rotate(bin_angle(ctr_lat, 128), junk, c1);
        rotate(bin_angle(lat2, 128), junk, c2);
        cc = shr(c1 * c2, 30);
        t = shr(cc * s2, 30);
        a = s1 * s1 + t * s2;
        if (a < 0) a = 0;
        if (a > (64'sd1 <<< 60)) a = 64'sd1 <<< 60;
        sy = floor_root(a << 2);
        sx = floor_root(((64'sd1 <<< 60) - a) << 2);
        x = sx;
        y = sy;
        z = 0;
        for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
            dx = shr(x, i);
            dy = shr(y, i);
            if (y > 0) begin
                tt = x + dy; y = y - dx; x = tt; z = z + $signed({32'd0, arc_of(i)});
            end else begin
                tt = x - dy; y = y + dx; x = tt; z = z - $signed({32'd0, arc_of(i)});
            end
        end
        if (z < 0) z = 0;
        if (z > (64'sd1 <<< 30)) z = 64'sd1 <<< 30;
        dist_q = (z * 64'd2623417457 + (64'd1 << 30)) >> 31;
        if (dist_q > 64'd1311768576) dist_q = 64'd1311768576;
        res.distance = dist_q[30:0];
        res.in_radius = (dist_q <= radius);
    endtask

    always @(posedge i_clk) begin
        t_fix_result exp_r;
        if (!i_rst_n) begin
            ctr_lat <= $signed(RST_CENTER_LAT);
            ctr_lon <= $signed(RST_CENTER_LON);
            radius  <= RST_RADIUS;
            fails   <= 0;
            expected_fixes.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_CENTER_LAT: ctr_lat <= $signed(i_cfg_data[29:0]);
                    REG_CENTER_LON: ctr_lon <= $signed(i_cfg_data);
                    REG_RADIUS:     radius <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && !i_stall_in) begin
                predict_fix(i_point_latitude, i_point_longitude, exp_r);
                expected_fixes.push_back(exp_r);
            end
            if (i_valid_out && !i_stall) begin
                if (expected_fixes.size() == 0) begin
                    if (fails < 10) $display("unexpected item: dist %0d flag %0d",
                                             i_distance, i_within_radius);
                    fails <= fails + 1;
                end else begin
                    exp_r = expected_fixes.pop_front();
                    if (exp_r.distance !== i_distance
                        || exp_r.in_radius !== i_within_radius) begin
                        if (fails < 10) $display("mismatch: dist exp %0d got %0d, flag exp %0d got %0d",
                                                 exp_r.distance, i_distance, exp_r.in_radius,
                                                 i_within_radius);
                        fails <= fails + 1;
                    end
                end
            end
        end
    end

endmodule

// ----- tb/testbench.sv -----
// testbench top for the haversine geofence check: stimulus, configuration phases and verdict
module testbench;
    import hgc_pkg::*;

    localparam int LATENCY = 40 + 2 * CORDIC_STAGES_DEF;
    localparam logic signed [29:0] LAT_MAX = 30'sd377487360;
    localparam logic signed [30:0] LON_MAX = 31'sd754974720;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = REG_CENTER_LAT;
    logic [30:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [29:0] point_lat = '0;
    logic [30:0] point_lon = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [30:0] out_distance;
    logic        out_within;
    int          fail_count;
    int          pending;
    logic        hold_off = 1'b0;
    logic [29:0] ctr_lat_shadow = RST_CENTER_LAT;
    logic [30:0] ctr_lon_shadow = RST_CENTER_LON;

    always #2 i_clk = ~i_clk;

    haversine_geofence_check dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .o_stall(in_stall),
        .i_point_latitude(point_lat), .i_point_longitude(point_lon),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_distance(out_distance), .o_within_radius(out_within)
    );

    hgc_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .i_stall_in(in_stall),
        .i_point_latitude(point_lat), .i_point_longitude(point_lon),
        .i_valid_out(out_valid), .i_stall(out_stall),
        .i_distance(out_distance), .i_within_radius(out_within),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver stall pattern, with a long hold-off counted here once requested
    initial begin
        int mode;
        int hold_left;
        bit hold_seen;
        mode = 0;
        hold_left = 0;
        hold_seen = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off && !hold_seen) begin
                hold_seen = 1'b1;
                hold_left = 3 * LATENCY;
            end else if (!hold_off) begin
                hold_seen = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                if ($urandom_range(0, 199) == 0) mode = $urandom_range(0, 3);
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 1) == 0);
                    default: out_stall <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    task automatic send_fix(input logic [29:0] lat, input logic [30:0] lon);
        point_lat <= lat;
        point_lon <= lon;
        in_valid <= 1'b1;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic idle_gap();
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [30:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
    endtask

    function automatic logic [29:0] rand_lat(input int k);
        case (k % 4)
            0: return 30'($signed(32'($urandom_range(0, 2 * 377487360))) - 377487360);
            1: return 30'($urandom);
            2: return 30'($signed(ctr_lat_shadow) + $signed(32'($urandom_range(0, 80000))) - 40000);
            default: return 30'($signed(ctr_lat_shadow) + $signed(32'($urandom_range(0, 8000000))) - 4000000);
        endcase
    endfunction

    function automatic logic [30:0] rand_lon(input int k);
        case (k % 4)
            0: return 31'($signed(32'($urandom_range(0, 2 * 754974720))) - 754974720);
            1: return 31'($urandom);
            2: return 31'($signed(ctr_lon_shadow) + $signed(32'($urandom_range(0, 80000))) - 40000);
            default: return 31'($signed(ctr_lon_shadow) + $signed(32'($urandom_range(0, 8000000))) - 4000000);
        endcase
    endfunction

    task automatic random_phase(input int count, input bit pressure);
        int burst, kind;
        burst = 0;
        for (int n = 0; n < count; n++) begin
            if (pressure && n == 20) hold_off <= 1'b1;
            if (burst == 0) begin
                idle_gap();
                burst = $urandom_range(1, 40);
            end
            burst--;
            kind = $urandom_range(0, 3);
            send_fix(rand_lat(kind), rand_lon(kind));
        end
        hold_off <= 1'b0;
    endtask

    initial begin
        #4000000;
        $display("status: fail");
        $finish;
    end

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        // directed: center itself, field extremes, poles, antipode, wrap
        send_fix(RST_CENTER_LAT, RST_CENTER_LON);
        send_fix(RST_CENTER_LAT + 30'd100000, RST_CENTER_LON);
        send_fix(LAT_MAX, LON_MAX);
        send_fix(-LAT_MAX, -LON_MAX);
        send_fix(LAT_MAX, 31'd0);
        send_fix(-LAT_MAX, 31'd0);
        send_fix(30'd0, 31'd0);
        send_fix(30'h1fffffff, 31'h3fffffff);
        send_fix(30'h20000000, 31'h40000000);
        send_fix(30'h3fffffff, 31'h7fffffff);
        send_fix(-RST_CENTER_LAT, RST_CENTER_LON + 31'd754974720);
        send_fix(RST_CENTER_LAT, RST_CENTER_LON + 31'd300000);
        send_fix(RST_CENTER_LAT, -LON_MAX);
        drain();
        random_phase(450, 1'b1);
        drain();
        // extremes of all registers
        write_reg(REG_CENTER_LAT, 31'(LAT_MAX));
        write_reg(REG_CENTER_LON, 31'(-LON_MAX));
        write_reg(REG_RADIUS, DIST_MAX);
        write_reg(REG_NONE, 31'h7fffffff);
        ctr_lat_shadow = LAT_MAX;
        ctr_lon_shadow = -LON_MAX;
        send_fix(LAT_MAX, -LON_MAX);
        send_fix(-LAT_MAX, LON_MAX);
        random_phase(300, 1'b0);
        drain();
        write_reg(REG_CENTER_LAT, 31'(-LAT_MAX));
        write_reg(REG_CENTER_LON, 31'(LON_MAX));
        write_reg(REG_RADIUS, 31'd0);
        ctr_lat_shadow = -LAT_MAX;
        ctr_lon_shadow = LON_MAX;
        send_fix(-LAT_MAX, LON_MAX);
        random_phase(300, 1'b0);
        drain();
        write_reg(REG_CENTER_LAT, 31'd0);
        write_reg(REG_CENTER_LON, 31'd0);
        write_reg(REG_RADIUS, 31'($urandom_range(0, 6553600)));
        ctr_lat_shadow = '0;
        ctr_lon_shadow = '0;
        random_phase(280, 1'b0);
        drain();
        if (fail_count == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

endmodule
